// ===== hw/rtl/sbnd_pkg.sv =====
// Shared types, constants and the header table for the sysex bank nibble deframer.
`timescale 1ns / 1ps
package sbnd_pkg;

    localparam int PROGRAM_BYTES   = 204;
    localparam int PROGRAM_SLOTS   = 40;
    localparam int MAX_FRAME_BYTES = 16384;

    localparam logic [7:0]  LAST_OFFSET  = 8'(PROGRAM_BYTES - 1);
    localparam logic [5:0]  LAST_PROGRAM = 6'(PROGRAM_SLOTS - 1);
    localparam logic [5:0]  PROGRAM_LIMIT = 6'(PROGRAM_SLOTS);
    localparam logic [13:0] LENGTH_LIMIT = 14'(MAX_FRAME_BYTES - 1);
    localparam logic [13:0] HEADER_LEN   = 14'd5;

    localparam logic [7:0] EOX_BYTE    = 8'hF7;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_HDR   = 3'd2;
    localparam logic [2:0] ST_TOO_MANY  = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_HOLD   = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data_byte;
        logic [5:0] program_index;
        logic [7:0] byte_offset;
        logic [5:0] program_count;
        logic [2:0] status;
    } t_result;

    function automatic logic [7:0] header_byte(input logic [2:0] pos);
        logic [7:0] b;
        unique case (pos)
            3'd0:    b = 8'hF0;
            3'd1:    b = 8'h0F;
            3'd2:    b = 8'h02;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/sbnd_core.sv =====
// Input register, frame state and per-byte decode of the deframer.
`timescale 1ns / 1ps
module sbnd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_space,
    output logic              o_push,
    output sbnd_pkg::t_result o_result
);
    import sbnd_pkg::*;

    logic        r_in_v;
    logic [7:0]  r_in_byte;
    t_phase      r_phase,      n_phase;
    logic [13:0] r_frame_len,  n_frame_len;
    logic        r_mismatch,   n_mismatch;
    logic [3:0]  r_low,        n_low;
    logic        r_have_low,   n_have_low;
    logic [7:0]  r_offset,     n_offset;
    logic [5:0]  r_prog,       n_prog;
    logic        fire;
    logic        is_eox;
    logic        too_long;
    logic [3:0]  nib;

    assign fire     = r_in_v && i_space;
    assign o_ready  = !r_in_v || fire;
    assign is_eox   = (r_in_byte == EOX_BYTE);
    assign too_long = (r_frame_len >= LENGTH_LIMIT);
    assign nib      = r_in_byte[3:0] & NIBBLE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_frame_len = r_frame_len;
        n_mismatch  = r_mismatch;
        n_low       = r_low;
        n_have_low  = r_have_low;
        n_offset    = r_offset;
        n_prog      = r_prog;
        if (r_phase == PH_SKIP || is_eox) begin
            if (is_eox) begin
                n_phase     = PH_HEADER;
                n_frame_len = '0;
                n_mismatch  = 1'b0;
                n_low       = '0;
                n_have_low  = 1'b0;
                n_offset    = '0;
                n_prog      = '0;
            end
        end else if (too_long) begin
            n_phase = PH_SKIP;
        end else begin
            n_frame_len = r_frame_len + 14'd1;
            unique case (r_phase)
                PH_HEADER: begin
                    if (r_frame_len < HEADER_LEN &&
                        r_in_byte != header_byte(r_frame_len[2:0])) begin
                        n_mismatch = 1'b1;
                    end
                    if (n_frame_len == HEADER_LEN) begin
                        n_phase = (n_mismatch) ? PH_HOLD : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (!r_have_low) begin
                        n_low      = nib;
                        n_have_low = 1'b1;
                    end else begin
                        n_have_low = 1'b0;
                        if (r_offset >= LAST_OFFSET) begin
                            n_offset = '0;
                            if (r_prog >= LAST_PROGRAM) begin
                                n_prog  = PROGRAM_LIMIT;
                                n_phase = PH_HOLD;
                            end else begin
                                n_prog = r_prog + 6'd1;
                            end
                        end else begin
                            n_offset = r_offset + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_push   = 1'b0;
        o_result = '0;
        if (r_phase != PH_SKIP) begin
            if (is_eox) begin
                o_push          = fire;
                o_result.is_end = 1'b1;
                unique case (r_phase)
                    PH_HEADER: o_result.status = ST_SHORT;
                    PH_HOLD:   o_result.status = r_mismatch ? ST_BAD_HDR : ST_TOO_MANY;
                    default: begin
                        o_result.status        = ST_OK;
                        o_result.program_count = r_prog;
                    end
                endcase
            end else if (too_long) begin
                o_push          = fire;
                o_result.is_end = 1'b1;
                o_result.status = ST_TOO_LONG;
            end else if (r_phase == PH_DATA && r_have_low) begin
                o_push                 = fire;
                o_result.data_byte     = {nib, r_low};
                o_result.program_index = r_prog;
                o_result.byte_offset   = r_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_frame_len <= '0;
            r_mismatch  <= 1'b0;
            r_low       <= '0;
            r_have_low  <= 1'b0;
            r_offset    <= '0;
            r_prog      <= '0;
        end else if (fire) begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_mismatch  <= n_mismatch;
            r_low       <= n_low;
            r_have_low  <= n_have_low;
            r_offset    <= n_offset;
            r_prog      <= n_prog;
        end
    end

endmodule

// ===== hw/rtl/sbnd_outbuf.sv =====
// Result register with a skid stage for the deframer output.
`timescale 1ns / 1ps
module sbnd_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sbnd_pkg::t_result i_result,
    output logic              o_space,
    output logic              o_valid,
    input  logic              i_ready,
    output sbnd_pkg::t_result o_result
);
    import sbnd_pkg::*;

    logic    r_out_v;
    logic    r_skid_v;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop      = r_out_v && i_ready;
    assign o_space  = !r_skid_v;
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid_v <= 1'b1;
            end else begin
                r_out_v <= 1'b1;
            end
        end else if (pop) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_v && !pop) begin
                r_skid <= i_result;
            end else begin
                r_out <= i_result;
            end
        end
    end

endmodule

// ===== hw/rtl/sysex_bank_nibble_deframer.sv =====
// Top level of the sysex bank dump deframer with nibble unpacking.
//
// Bytes of a system-exclusive bank dump arrive on the slave stream, one per
// transfer. The first five bytes of a frame are checked against the fixed
// header, then byte pairs are joined into data bytes (low nibble first).
// Each data byte leaves on the master stream with tuser low; the 0xF7 that
// ends a frame gives one status transfer with tuser high and, if it ends in the
// data phase, the number of complete programs. An overlong frame gives a status
// transfer at once and the bytes up to the next 0xF7 are dropped without any output.
// A byte is held in the input register; its result is decoded from there and
// written to the output register (or to the skid stage if the output is held),
// from which it is offered on the master stream. One byte is accepted in
// every cycle while the receiver keeps up. When the receiver stalls, a skid
// stage takes one more result; once it is full and the input register holds
// a byte, s_axis_tready stays low until the receiver takes a result.
// After reset the block waits for the header of a new frame and both
// streams are empty.
`timescale 1ns / 1ps
module sysex_bank_nibble_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] sysex_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [13:8] program_index,
                                        // [21:14] byte_offset, [27:22] program_count,
                                        // [30:28] status, [31] zero
    output logic        m_axis_tuser    // [0] is_end
);
    import sbnd_pkg::*;

    logic    space;
    logic    push;
    t_result core_result;
    t_result out_result;

    sbnd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_space  (space),
        .o_push   (push),
        .o_result (core_result)
    );

    sbnd_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (core_result),
        .o_space  (space),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tuser = out_result.is_end;
    assign m_axis_tdata = {1'b0, out_result.status, out_result.program_count,
                           out_result.byte_offset, out_result.program_index,
                           out_result.data_byte};

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> space)
        else $error("result pushed while the output buffer is full");

    a_full_means_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !space |-> m_axis_tvalid)
        else $error("skid stage holds a result while the output register is empty");

    a_data_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:22] == 10'd0))
        else $error("data result carries a count or status");

    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[21:0] == 22'd0 && m_axis_tdata[30:28] <= ST_TOO_LONG))
        else $error("end result carries data fields or an unknown status");

endmodule
